@@ rtl/cah_pkg.sv @@
// Shared types and constants for the command acknowledge handshake tracker.
package cah_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IDW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [2:0] {
    OP_CLEAR_ALL  = 3'd0,
    OP_PRESEND    = 3'd1,
    OP_ACK        = 3'd2,
    OP_WAIT_BEGIN = 3'd3,
    OP_WAIT_END   = 3'd4
  } op_t;

  // Slot handshake codes; the same codes are reported as prior_state.
  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_PRESEND    = 3'd1,
    ST_WAIT       = 3'd2,
    ST_ACK_BEFORE = 3'd3,
    ST_ACK_AFTER  = 3'd4
  } slot_st_t;

  typedef struct packed {
    logic       success;
    logic       must_wait;
    logic       id_out_of_range;
    logic       abnormal;
    logic [2:0] prior_state;
  } result_t;

  typedef struct packed {
    slot_st_t state;
    logic     okay;
  } slot_rec_t;

endpackage

@@ rtl/cah_slot_update.sv @@
// Next record and result for one operation on one in-range slot.
module cah_slot_update import cah_pkg::*; (
  input  logic [2:0] opcode,
  input  slot_rec_t  cur,
  output slot_rec_t  nxt,
  output result_t    res
);

  always_comb begin
    nxt = cur;
    res = '0;
    res.prior_state = cur.state;
    case (opcode)
      OP_PRESEND: begin
        if (cur.state == ST_IDLE) begin
          nxt.state   = ST_PRESEND;
          res.success = 1'b1;
        end else begin
          res.abnormal = 1'b1;
        end
      end
      OP_ACK: begin
        if (cur.state == ST_WAIT) begin
          nxt.state = ST_ACK_AFTER;
          nxt.okay  = 1'b1;
        end else if (cur.state == ST_PRESEND) begin
          nxt.state = ST_ACK_BEFORE;
          nxt.okay  = 1'b1;
        end else if (cur.state != ST_IDLE) begin
          res.abnormal = 1'b1;
        end
      end
      OP_WAIT_BEGIN: begin
        if (cur.state == ST_ACK_BEFORE) begin
          nxt.state   = ST_IDLE;
          res.success = cur.okay;
        end else if (cur.state == ST_PRESEND) begin
          nxt.state     = ST_WAIT;
          res.must_wait = 1'b1;
        end else begin
          res.abnormal = 1'b1;
        end
      end
      OP_WAIT_END: begin
        // completion or timeout: always drop back to idle
        nxt.state    = ST_IDLE;
        res.success  = (cur.state == ST_ACK_AFTER) && cur.okay;
        res.abnormal = !((cur.state == ST_ACK_AFTER) && cur.okay);
      end
      default: begin
        res.prior_state = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/command_ack_handshake_tracker_core.sv @@
// Top level of the command acknowledge handshake tracker.
// Pipeline: input register, then result register. Throughput: one transfer
// per cycle while out_stall does not hold the result register, set by the single
// read-modify-write of the slot record file between the two registers.
// Reset: synchronous, active high; all slots go idle with okay cleared and
// both pipeline registers empty.
module command_ack_handshake_tracker_core import cah_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [3:0] slot_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       success,
  output logic       must_wait,
  output logic       id_out_of_range,
  output logic       abnormal,
  output logic [2:0] prior_state
);

  slot_rec_t  slots [SLOT_COUNT];

  logic       s1_valid;
  logic [2:0] s1_opcode;
  logic [3:0] s1_slot_id;
  logic       s1_advance;

  logic       in_range;
  logic       any_busy;
  slot_rec_t  cur_rec;
  slot_rec_t  nxt_rec;
  result_t    slot_res;
  result_t    res_next;
  result_t    res;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  assign in_range = {1'b0, s1_slot_id} < 5'(SLOT_COUNT);

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slots[i].state != ST_IDLE) any_busy = 1'b1;
    end
  end

  always_comb begin
    cur_rec = '{state: ST_IDLE, okay: 1'b0};
    if (in_range) cur_rec = slots[s1_slot_id[SLOT_IDW-1:0]];
  end

  cah_slot_update u_update (
    .opcode (s1_opcode),
    .cur    (cur_rec),
    .nxt    (nxt_rec),
    .res    (slot_res)
  );

  always_comb begin
    res_next = '0;
    if (s1_opcode == OP_CLEAR_ALL) begin
      res_next.abnormal = any_busy;
    end else if (s1_opcode <= OP_WAIT_END) begin
      if (in_range) res_next = slot_res;
      else          res_next.id_out_of_range = 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_opcode  <= opcode;
      s1_slot_id <= slot_id;
    end
  end

  // slot record file, updated as the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= '{state: ST_IDLE, okay: 1'b0};
      end
    end else if (s1_advance) begin
      if (s1_opcode == OP_CLEAR_ALL) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          slots[i] <= '{state: ST_IDLE, okay: 1'b0};
        end
      end else if (in_range && s1_opcode <= OP_WAIT_END) begin
        slots[s1_slot_id[SLOT_IDW-1:0]] <= nxt_rec;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) res <= res_next;
  end

  assign success         = res.success;
  assign must_wait       = res.must_wait;
  assign id_out_of_range = res.id_out_of_range;
  assign abnormal        = res.abnormal;
  assign prior_state     = res.prior_state;

endmodule

@@ tb/handshake_result_checker.sv @@
// Checker that predicts every handshake tracker result and scores the actual results.
`timescale 1ns / 1ps
module handshake_result_checker import cah_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [3:0] slot_id,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       success,
  input  logic       must_wait,
  input  logic       id_out_of_range,
  input  logic       abnormal,
  input  logic [2:0] prior_state,
  output int         mismatch_count,
  output int         pending_count
);

  localparam int REPORT_LIMIT = 10;

  slot_st_t slot_state [SLOT_COUNT];
  logic     slot_okay  [SLOT_COUNT];
  result_t  expected_results [$];
  result_t  oldest;

  // Apply one command to the shadow slot records and return its result.
  function automatic result_t track_command(input logic [2:0] op, input logic [3:0] id);
    result_t             r;
    slot_st_t            s;
    logic [SLOT_IDW-1:0] idx;
    r = '0;
    if (op == OP_CLEAR_ALL) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_state[i] != ST_IDLE) r.abnormal = 1'b1;
        slot_state[i] = ST_IDLE;
        slot_okay[i]  = 1'b0;
      end
    end else if (op <= OP_WAIT_END) begin
      if (id >= SLOT_COUNT) begin
        r.id_out_of_range = 1'b1;
      end else begin
        idx = id[SLOT_IDW-1:0];
        s = slot_state[idx];
        r.prior_state = s;
        case (op)
          OP_PRESEND: begin
            if (s == ST_IDLE) begin
              slot_state[idx] = ST_PRESEND;
              r.success = 1'b1;
            end else begin
              r.abnormal = 1'b1;
            end
          end
          OP_ACK: begin
            if (s == ST_WAIT) begin
              slot_okay[idx]  = 1'b1;
              slot_state[idx] = ST_ACK_AFTER;
            end else if (s == ST_PRESEND) begin
              slot_okay[idx]  = 1'b1;
              slot_state[idx] = ST_ACK_BEFORE;
            end else if (s != ST_IDLE) begin
              r.abnormal = 1'b1;
            end
          end
          OP_WAIT_BEGIN: begin
            if (s == ST_ACK_BEFORE) begin
              r.success       = slot_okay[idx];
              slot_state[idx] = ST_IDLE;
            end else if (s == ST_PRESEND) begin
              slot_state[idx] = ST_WAIT;
              r.must_wait     = 1'b1;
            end else begin
              r.abnormal = 1'b1;
            end
          end
          default: begin
            // completion or timeout: the slot always returns to idle
            if (s == ST_ACK_AFTER) r.success = slot_okay[idx];
            if (s != ST_ACK_AFTER || !r.success) r.abnormal = 1'b1;
            slot_state[idx] = ST_IDLE;
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [2:0] want, input logic [2:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_state[i] = ST_IDLE;
        slot_okay[i]  = 1'b0;
      end
      expected_results.delete();
      mismatch_count = 0;
      pending_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result transfer with no expectation pending", $time);
        end else begin
          oldest = expected_results.pop_front();
          check_field("success", 3'(oldest.success), 3'(success));
          check_field("must_wait", 3'(oldest.must_wait), 3'(must_wait));
          check_field("id_out_of_range", 3'(oldest.id_out_of_range), 3'(id_out_of_range));
          check_field("abnormal", 3'(oldest.abnormal), 3'(abnormal));
          check_field("prior_state", oldest.prior_state, prior_state);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(track_command(opcode, slot_id));
      pending_count <= expected_results.size();
    end
  end

endmodule

@@ tb/tb_command_ack_handshake_tracker_core.sv @@
// Testbench top: drives command transfers and result stalls, then reports the verdict.
`timescale 1ns / 1ps
module tb_command_ack_handshake_tracker_core import cah_pkg::*; ();

  localparam int PHASE_ITEMS  = 460;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef enum int {FLOW_EARLY_ACK, FLOW_LATE_ACK, FLOW_TIMEOUT} flow_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] opcode;
  logic [3:0] slot_id;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       success;
  logic       must_wait;
  logic       id_out_of_range;
  logic       abnormal;
  logic [2:0] prior_state;

  int    send_idle_pct;
  int    recv_stall_pct;
  int    cycle_count = 0;
  int    mismatch_count;
  int    pending_count;
  flow_t flow_kind [SLOT_COUNT];
  int    flow_pos  [SLOT_COUNT];

  command_ack_handshake_tracker_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .slot_id         (slot_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .success         (success),
    .must_wait       (must_wait),
    .id_out_of_range (id_out_of_range),
    .abnormal        (abnormal),
    .prior_state     (prior_state)
  );

  handshake_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .slot_id         (slot_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .success         (success),
    .must_wait       (must_wait),
    .id_out_of_range (id_out_of_range),
    .abnormal        (abnormal),
    .prior_state     (prior_state),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall   <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("tb_command_ack_handshake_tracker_core: FAIL");
    $finish;
  end

  // Idle at random, then hold the transfer until it is taken.
  task automatic push_op(input logic [2:0] op, input logic [3:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    slot_id  <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [2:0]          op;
    logic [3:0]          sid;
    logic [SLOT_IDW-1:0] fid;
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = OP_CLEAR_ALL;
    slot_id        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (flow_pos[i]) begin
      flow_pos[i]  = 0;
      flow_kind[i] = FLOW_EARLY_ACK;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: every operation from every interesting slot state
    push_op(OP_CLEAR_ALL, 4'hF);
    push_op(OP_PRESEND, 4'd0);
    push_op(OP_PRESEND, 4'd0);
    push_op(OP_ACK, 4'd0);
    push_op(OP_ACK, 4'd0);
    push_op(OP_WAIT_BEGIN, 4'd0);
    push_op(OP_PRESEND, 4'd1);
    push_op(OP_WAIT_BEGIN, 4'd1);
    push_op(OP_WAIT_BEGIN, 4'd1);
    push_op(OP_ACK, 4'd1);
    push_op(OP_WAIT_BEGIN, 4'd1);
    push_op(OP_ACK, 4'd1);
    push_op(OP_WAIT_END, 4'd1);
    push_op(OP_WAIT_END, 4'd2);
    push_op(OP_PRESEND, 4'd3);
    push_op(OP_WAIT_END, 4'd3);
    push_op(OP_PRESEND, 4'd4);
    push_op(OP_WAIT_BEGIN, 4'd4);
    push_op(OP_WAIT_END, 4'd4);
    push_op(OP_ACK, 4'd5);
    push_op(OP_WAIT_BEGIN, 4'd5);
    push_op(OP_PRESEND, 4'(SLOT_COUNT - 1));
    push_op(OP_ACK, 4'(SLOT_COUNT));
    push_op(OP_PRESEND, 4'hF);
    for (int k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++)
      push_op(3'(k), 4'(SLOT_COUNT - 1));
    push_op(OP_CLEAR_ALL, 4'd0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 14;
          recv_stall_pct <= 86;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct <= 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 80) begin
          // advance one slot through a well-formed handshake
          fid = SLOT_IDW'($urandom_range(SLOT_COUNT - 1));
          sid = 4'(fid);
          if (flow_pos[fid] == 0) begin
            flow_kind[fid] = flow_t'($urandom_range(2));
            op = OP_PRESEND;
          end else begin
            case (flow_kind[fid])
              FLOW_EARLY_ACK: op = (flow_pos[fid] == 1) ? OP_ACK : OP_WAIT_BEGIN;
              FLOW_LATE_ACK:  op = (flow_pos[fid] == 1) ? OP_WAIT_BEGIN :
                                   (flow_pos[fid] == 2) ? OP_ACK : OP_WAIT_END;
              default:        op = (flow_pos[fid] == 1) ? OP_WAIT_BEGIN : OP_WAIT_END;
            endcase
          end
          flow_pos[fid] = (flow_pos[fid] + 1) % ((flow_kind[fid] == FLOW_LATE_ACK) ? 4 : 3);
        end else begin
          op  = 3'($urandom_range(7));
          sid = 4'($urandom_range(15));
          if (op == OP_CLEAR_ALL) begin
            foreach (flow_pos[i]) flow_pos[i] = 0;
          end
        end
        push_op(op, sid);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_command_ack_handshake_tracker_core: PASS");
    end else begin
      $display("tb_command_ack_handshake_tracker_core: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cah_pkg.sv
rtl/cah_slot_update.sv
rtl/command_ack_handshake_tracker_core.sv
tb/handshake_result_checker.sv
tb/tb_command_ack_handshake_tracker_core.sv
